### rtl/wbps_pkg.sv
// Package for the wildcard byte pattern search unit.
// Holds the configuration and record types and the register index codes.
// No dependencies.
`timescale 1ns / 1ps

package wbps_pkg;

  localparam int unsigned PatBytes = 16;

  typedef enum logic [1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_WILDCARD = 2'd2,
    CFG_PAT_LEN  = 2'd3
  } wbps_cfg_idx_e;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [7:0]  wildcard_value;
    logic [4:0]  pattern_length;
  } wbps_cfg_t;

  // One classified byte: whether the alignment ending at it matches, the
  // start offset of that alignment and the end-of-buffer mark.
  typedef struct packed {
    logic        hit;
    logic        last;
    logic [31:0] offset;
  } wbps_rec_t;

endpackage

### rtl/wbps_front.sv
// Front end: accepts buffer bytes, keeps the byte window and count and
// classifies each byte by a parallel window compare. Uses wbps_pkg.
`timescale 1ns / 1ps

module wbps_front import wbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  wbps_cfg_t  cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output wbps_rec_t  q_rec_o
);

  localparam int unsigned LenBits = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int unsigned NW      = (LenBits > 5) ? LenBits : 5;

  logic [7:0]    win_q [MAX_PATTERN_BYTES];
  logic [7:0]    win_d [MAX_PATTERN_BYTES];
  logic [31:0]   seen_q;
  logic [31:0]   seen_d;
  logic [NW-1:0] len_ext;
  logic [NW-1:0] n_eff;
  logic [7:0]    pat [PatBytes];
  logic [MAX_PATTERN_BYTES-1:0] pos_ok;
  logic          accept;
  logic          count_ge;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;

  assign len_ext = NW'(cfg_i.pattern_length);
  assign n_eff   = (len_ext > NW'(MAX_PATTERN_BYTES)) ? NW'(MAX_PATTERN_BYTES) : len_ext;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      pat[j]     = cfg_i.pattern_low[8*j +: 8];
      pat[j + 8] = cfg_i.pattern_high[8*j +: 8];
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      if (k == 0) begin
        win_d[k] = data_byte_i;
      end else begin
        win_d[k] = win_q[k-1];
      end
    end
  end

  // Window position k (newest first) lines up with pattern byte n-1-k.
  always_comb begin
    logic [7:0] p;
    for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
      p = 8'h00;
      for (int j = 0; j < PatBytes; j++) begin
        if ((k < int'(n_eff)) && (j == int'(n_eff) - 1 - k)) begin
          p = pat[j];
        end
      end
      pos_ok[k] = (k >= int'(n_eff)) || (p == cfg_i.wildcard_value) || (p == win_d[k]);
    end
  end

  assign seen_d   = (seen_q != '1) ? seen_q + 32'd1 : seen_q;
  assign count_ge = seen_d >= 32'(n_eff);

  always_comb begin
    q_rec_o.hit    = (n_eff == '0) || (count_ge && (&pos_ok));
    q_rec_o.last   = last_byte_i;
    q_rec_o.offset = (n_eff == '0) ? 32'd0 : seen_d - 32'(n_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        win_q[k] <= '0;
      end
    end else if (accept) begin
      if (last_byte_i) begin
        seen_q <= '0;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
          win_q[k] <= '0;
        end
      end else begin
        seen_q <= seen_d;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
          win_q[k] <= win_d[k];
        end
      end
    end
  end

endmodule

### rtl/wbps_fifo.sv
// Two-entry queue of classified byte records between front and back end.
// Uses wbps_pkg.
`timescale 1ns / 1ps

module wbps_fifo import wbps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  wbps_rec_t push_rec_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output wbps_rec_t pop_rec_o
);

  wbps_rec_t  mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_rec_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

### rtl/wbps_back.sv
// Back end: records the first match of a buffer and delivers one result at
// its last byte through an output register. Uses wbps_pkg.
`timescale 1ns / 1ps

module wbps_back import wbps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rec_valid_i,
  input  wbps_rec_t   rec_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        search_status_o,
  output logic [31:0] match_offset_o
);

  logic        seen_q;
  logic [31:0] first_q;
  logic        out_valid_q;
  logic        status_q;
  logic [31:0] offset_q;
  logic        seen_d;
  logic [31:0] first_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = rec_valid_i && (!rec_i.last || slot_free);
  assign seen_d    = seen_q || rec_i.hit;
  assign first_d   = seen_q ? first_q : rec_i.offset;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      first_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        if (rec_i.last) begin
          seen_q      <= 1'b0;
          first_q     <= '0;
          out_valid_q <= 1'b1;
        end else begin
          seen_q  <= seen_d;
          first_q <= first_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && rec_i.last) begin
      status_q <= !seen_d;
      offset_q <= seen_d ? first_d : 32'd0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign search_status_o = status_q;
  assign match_offset_o  = offset_q;

endmodule

### rtl/wildcard_byte_pattern_search_unit.sv
// Top level of the wildcard byte pattern search unit: configuration registers,
// front end, record queue and back end. Uses wbps_pkg and the wbps modules.
// The unit takes one buffer byte per clock cycle unless the record queue is
// full; the front end compares the byte window against the pattern in
// parallel. The record of a buffer's last byte passes through the queue to
// the back end, which loads the result into the output register; a two-entry
// queue and the output register let input continue while a result waits to be taken.
`timescale 1ns / 1ps

module wildcard_byte_pattern_search_unit import wbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        search_status_o,
  output logic [31:0] match_offset_o
);

  wbps_cfg_t cfg_q;
  wbps_rec_t push_rec;
  wbps_rec_t pop_rec;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_low    <= '0;
      cfg_q.pattern_high   <= '0;
      cfg_q.wildcard_value <= '0;
      cfg_q.pattern_length <= 5'd1;
    end else if (cfg_we_i) begin
      case (wbps_cfg_idx_e'(cfg_index_i))
        CFG_PAT_LOW:  cfg_q.pattern_low    <= cfg_wdata_i;
        CFG_PAT_HIGH: cfg_q.pattern_high   <= cfg_wdata_i;
        CFG_WILDCARD: cfg_q.wildcard_value <= cfg_wdata_i[7:0];
        CFG_PAT_LEN:  cfg_q.pattern_length <= cfg_wdata_i[4:0];
        default: begin
        end
      endcase
    end
  end

  wbps_front #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (push),
    .q_rec_o     (push_rec)
  );

  wbps_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_rec_o  (pop_rec)
  );

  wbps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_valid_i     (q_valid),
    .rec_i           (pop_rec),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .search_status_o (search_status_o),
    .match_offset_o  (match_offset_o)
  );

endmodule

### rtl/wbps_checker.sv
// Port-level checker for the wildcard byte pattern search unit, bound to the
// top level. Depends only on the top level's ports.
`timescale 1ns / 1ps

module wbps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        last_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        search_status_o,
  input logic [31:0] match_offset_o
);

  logic [2:0] pending_q;
  logic       in_last_acc;
  logic       out_acc;

  assign in_last_acc = in_valid_i && !in_stall_o && last_byte_i;
  assign out_acc     = out_valid_o && !out_stall_i;

  // Counts buffers whose last byte was accepted but whose result is not taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + {2'b00, in_last_acc} - {2'b00, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(search_status_o)
      && $stable(match_offset_o))
    else $error("stalled result changed or was dropped");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && search_status_o |-> match_offset_o == 32'd0)
    else $error("not-found result carries a non-zero offset");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 3'd0)
    else $error("result shown without a completed buffer");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("more buffers in flight than the unit can hold");

endmodule

bind wildcard_byte_pattern_search_unit wbps_checker u_wbps_checker (.*);

### bench/wildcard_byte_pattern_search_unit_tb.sv
// Self-checking testbench for the wildcard byte pattern search unit.
// It drives a directed table and then random buffers, predicts every search result
// and compares the results field by field. Depends on wbps_pkg and the unit's RTL.
`timescale 1ns / 1ps

module wildcard_byte_pattern_search_unit_tb;
  import wbps_pkg::*;

  localparam logic STATUS_FOUND  = 1'b0;
  localparam logic STATUS_ABSENT = 1'b1;

  localparam int CycleLimit     = 200000;
  localparam int SettleCycles   = 8;
  localparam int HoldCycles     = 400;
  localparam int ItemsPerPhase  = 480;
  localparam int FramesPerSetup = 6;
  localparam int PrintedReports = 40;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    wbps_cfg_idx_e index;
    logic [63:0]   wdata;
    logic [7:0]    data;
    logic          last;
    logic          typed;
    logic          status;
    logic [31:0]   offset;
  } stim_row_t;

  typedef struct packed {
    logic        status;
    logic [31:0] offset;
  } search_result_t;

  localparam stim_row_t DirectedRows [24] = '{
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'hFF, 1'b1, 1'b1, STATUS_FOUND,  32'd0},
    '{ROW_CFG,  CFG_WILDCARD, 64'hFFFF_FFFF_FFFF_FF5A, 8'h00, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'h00, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'hFF, 1'b1, 1'b1, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'hFF, 1'b1, 1'b1, STATUS_ABSENT, 32'd0},
    '{ROW_CFG,  CFG_PAT_LEN,  64'hFFFF_FFFF_FFFF_FFE0, 8'h00, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'h33, 1'b1, 1'b1, STATUS_FOUND,  32'd0},
    '{ROW_CFG,  CFG_PAT_LEN,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_CFG,  CFG_PAT_LOW,  64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_CFG,  CFG_PAT_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'hFF, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'hFF, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'hFF, 1'b1, 1'b1, STATUS_ABSENT, 32'd0},
    '{ROW_CFG,  CFG_PAT_LEN,  64'h2,                 8'h00, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_CFG,  CFG_PAT_LOW,  64'h5A01,              8'h00, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'h02, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'h01, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'hEE, 1'b1, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'h10, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_CFG,  CFG_PAT_LOW,  64'h2010,              8'h00, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'h20, 1'b1, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_CFG,  CFG_PAT_LEN,  64'd17,                8'h00, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'h00, 1'b0, 1'b0, STATUS_FOUND,  32'd0},
    '{ROW_BYTE, CFG_PAT_LOW,  64'h0,                 8'h00, 1'b1, 1'b1, STATUS_ABSENT, 32'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        search_status_o;
  logic [31:0] match_offset_o;

  wbps_cfg_t      search_cfg = '{pattern_low: '0, pattern_high: '0, wildcard_value: '0,
                                 pattern_length: 5'd1};
  logic [7:0]     recent [PatBytes];
  logic [31:0]    bytes_in_frame = '0;
  logic           match_found = 1'b0;
  logic [31:0]    match_start = '0;
  search_result_t pending_results [$];
  search_result_t typed_result;
  logic           typed_armed = 1'b0;

  int  mismatches = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 38;
  int  recv_idle_pct = 61;
  int  hold_left = 0;
  logic hold_request = 1'b0;

  wildcard_byte_pattern_search_unit dut (.*);

  initial begin
    foreach (recent[k]) recent[k] = '0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PrintedReports)
      $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, field, got, want);
  endtask

  task automatic scan_byte(input logic [7:0] value, input logic is_last);
    logic [127:0]   pat;
    int unsigned    n;
    logic           hit;
    search_result_t res;
    pat = {search_cfg.pattern_high, search_cfg.pattern_low};
    n = (search_cfg.pattern_length > PatBytes) ? PatBytes : search_cfg.pattern_length;
    if (n == 0 && !match_found) begin
      match_found = 1'b1;
      match_start = '0;
    end
    for (int k = PatBytes - 1; k > 0; k--) recent[k] = recent[k - 1];
    recent[0] = value;
    if (bytes_in_frame != '1) bytes_in_frame++;
    if (n > 0 && !match_found && bytes_in_frame >= n) begin
      hit = 1'b1;
      for (int j = 0; j < n; j++) begin
        if (pat[8 * j +: 8] != search_cfg.wildcard_value && pat[8 * j +: 8] != recent[n - 1 - j])
          hit = 1'b0;
      end
      if (hit) begin
        match_found = 1'b1;
        match_start = bytes_in_frame - n;
      end
    end
    if (is_last) begin
      res.status = match_found ? STATUS_FOUND : STATUS_ABSENT;
      res.offset = match_found ? match_start : '0;
      if (typed_armed) begin
        res = typed_result;
        typed_armed = 1'b0;
      end
      pending_results.push_back(res);
      foreach (recent[k]) recent[k] = '0;
      bytes_in_frame = '0;
      match_found = 1'b0;
      match_start = '0;
    end
  endtask

  task automatic check_result(input logic status, input logic [31:0] offset);
    search_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("result with nothing pending, match_offset", offset, '0);
      return;
    end
    want = pending_results.pop_front();
    if (status !== want.status) report_mismatch("search_status", 32'(status), 32'(want.status));
    if (offset !== want.offset) report_mismatch("match_offset", offset, want.offset);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result(search_status_o, match_offset_o);
      if (in_valid_i && !in_stall_o) scan_byte(data_byte_i, last_byte_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // A long hold-off lets requests pile up until the unit stalls its input.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_byte(input logic [7:0] value, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= value;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input wbps_cfg_idx_e index, input logic [63:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value;
    case (index)
      CFG_PAT_LOW:  search_cfg.pattern_low = value;
      CFG_PAT_HIGH: search_cfg.pattern_high = value;
      CFG_WILDCARD: search_cfg.wildcard_value = value[7:0];
      CFG_PAT_LEN:  search_cfg.pattern_length = value[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_random_pattern();
    logic [7:0]   wild;
    logic [127:0] pat;
    logic [63:0]  junk;
    logic [4:0]   len;
    wild = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'hFF : 8'h00) : 8'($urandom);
    case ($urandom_range(7))
      0: pat = '0;
      1: pat = '1;
      default: begin
        for (int j = 0; j < 16; j++)
          pat[8 * j +: 8] = ($urandom_range(3) == 0) ? wild : 8'($urandom);
      end
    endcase
    case ($urandom_range(9))
      0: len = 5'd0;
      1: len = 5'd1;
      2: len = 5'd16;
      3: len = 5'($urandom_range(31, 17));
      4, 5: len = 5'($urandom_range(15, 9));
      default: len = 5'($urandom_range(8, 2));
    endcase
    junk = {$urandom, $urandom};
    write_reg(CFG_PAT_LOW, pat[63:0]);
    write_reg(CFG_PAT_HIGH, pat[127:64]);
    write_reg(CFG_WILDCARD, {junk[63:8], wild});
    write_reg(CFG_PAT_LEN, {junk[63:5], len});
  endtask

  // Most buffers carry a planted copy of the pattern, with wildcard positions
  // filled at random; the other bytes favour pattern values to give near misses.
  task automatic send_frame(inout int sent);
    logic [127:0] pat;
    logic [7:0]   frame [$];
    int unsigned  n;
    int unsigned  len;
    int unsigned  pos;
    pat = {search_cfg.pattern_high, search_cfg.pattern_low};
    n = (search_cfg.pattern_length > PatBytes) ? PatBytes : search_cfg.pattern_length;
    len = ($urandom_range(19) == 0) ? $urandom_range(n + 60, 1) : $urandom_range(n + 10, 1);
    for (int k = 0; k < len; k++)
      frame.push_back($urandom_range(1) ? 8'($urandom) : pat[8 * $urandom_range(15) +: 8]);
    if (n > 0 && len >= n && $urandom_range(9) < 6) begin
      pos = $urandom_range(len - n);
      for (int j = 0; j < n; j++)
        frame[pos + j] = (pat[8 * j +: 8] == search_cfg.wildcard_value) ? 8'($urandom)
                                                                         : pat[8 * j +: 8];
    end
    foreach (frame[k]) push_byte(frame[k], k == len - 1);
    sent += len;
  endtask

  initial begin
    stim_row_t row;
    int        sent;
    int        frames;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < $size(DirectedRows); i++) begin
      row = DirectedRows[i];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        write_reg(row.index, row.wdata);
      end else begin
        typed_armed = row.typed;
        typed_result = '{status: row.status, offset: row.offset};
        push_byte(row.data, row.last);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      frames = 0;
      while (sent < ItemsPerPhase) begin
        if (frames % FramesPerSetup == 0) begin
          wait_idle();
          load_random_pattern();
          if (phase == 2 && frames == 0) hold_request = 1'b1;
        end
        send_frame(sent);
        frames++;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
